@@ sv/pat_pkg.sv @@
// ----------------------------------------------------------------------------
// pat_pkg
// shared types and constants for the pat section parser
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

  localparam int unsigned MAX_SECTION_BYTES_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF       = 4;

  typedef enum logic [1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [15:0] program_number;
    logic [12:0] map_pid;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t data;
  } res_push_t;

endpackage

`default_nettype wire

@@ sv/pat_front.sv @@
// ----------------------------------------------------------------------------
// pat_front
// byte classifier: tracks section position and header fields, emits results
// ----------------------------------------------------------------------------
`default_nettype none

module pat_front #(
  parameter int unsigned MAX_SECTION_BYTES = pat_pkg::MAX_SECTION_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire pat_pkg::in_item_t item,
  input  wire logic [7:0]        exp_tid,
  output pat_pkg::res_push_t     res
);
  import pat_pkg::*;

  localparam int unsigned LW = 13;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_SECTION_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [11:0] pos_r, pos_nxt;
  logic [11:0] len_r, len_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [15:0] sid_r, sid_nxt;
  logic [4:0]  ver_r, ver_nxt;
  logic [7:0]  sec_r, sec_nxt;
  logic [7:0]  last_r, last_nxt;
  logic [23:0] entry_r, entry_nxt;

  logic [11:0]   pos_inc;
  logic [LW-1:0] pos_w;
  logic [LW-1:0] len_w;
  logic [LW-1:0] last_pos;
  logic [7:0]    b;
  logic          hdr_chk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      hdr_ok_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      hdr_ok_r <= hdr_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    sid_r   <= sid_nxt;
    ver_r   <= ver_nxt;
    sec_r   <= sec_nxt;
    last_r  <= last_nxt;
    entry_r <= entry_nxt;
  end

  assign b       = item.data_byte;
  assign pos_inc = pos_r + 12'd1;
  assign pos_w   = {1'b0, pos_inc};
  assign len_w   = {1'b0, len_r};
  assign last_pos = ((len_w + LW'(2)) < LW'(7)) ? LW'(7) : (len_w + LW'(2));

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    hdr_ok_nxt = hdr_ok_r;
    sid_nxt    = sid_r;
    ver_nxt    = ver_r;
    sec_nxt    = sec_r;
    last_nxt   = last_r;
    entry_nxt  = entry_r;
    hdr_chk    = 1'b0;
    res        = '0;
    if (accept) begin
      if (item.section_start) begin
        phase_nxt  = PH_BODY;
        pos_nxt    = '0;
        hdr_ok_nxt = (b == exp_tid);
        len_nxt    = '0;
        entry_nxt  = '0;
      end else if (phase_r == PH_BODY) begin
        pos_nxt = pos_inc;
        unique case (pos_inc)
          12'd1: begin
            hdr_ok_nxt = hdr_ok_r && b[7] && !b[6];
            len_nxt    = {b[3:0], 8'h00};
          end
          12'd2: begin
            len_nxt    = len_r | {4'h0, b};
            hdr_ok_nxt = hdr_ok_r && ((LW'(len_r | {4'h0, b}) + LW'(3)) <= MAX_LEN);
          end
          12'd3: sid_nxt = {b, 8'h00};
          12'd4: sid_nxt = sid_r | {8'h00, b};
          12'd5: begin
            ver_nxt    = b[5:1];
            hdr_chk    = hdr_ok_r && b[0];
            hdr_ok_nxt = hdr_chk;
            if (!hdr_chk) begin
              phase_nxt             = PH_SKIP;
              res.valid             = 1'b1;
              res.data.result_kind  = KIND_REJECT;
            end
          end
          12'd6: sec_nxt = b;
          default: begin
            if (pos_inc == 12'd7) begin
              last_nxt = b;
            end
            if (pos_w == last_pos) begin
              phase_nxt                    = PH_IDLE;
              res.valid                    = 1'b1;
              res.data.result_kind         = KIND_DONE;
              res.data.stream_id           = sid_r;
              res.data.version             = ver_r;
              res.data.section_index       = sec_r;
              res.data.last_section_index  = (pos_inc == 12'd7) ? b : last_r;
            end else if (pos_inc >= 12'd8) begin
              if (pos_inc[1:0] == 2'b11) begin
                entry_nxt = '0;
                if ((pos_w + LW'(2)) <= len_w && entry_r[23:8] != 16'h0000) begin
                  res.valid                = 1'b1;
                  res.data.result_kind     = KIND_ENTRY;
                  res.data.program_number  = entry_r[23:8];
                  res.data.map_pid         = {entry_r[4:0], b};
                end
              end else begin
                entry_nxt = {entry_r[15:0], b};
              end
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/pat_queue.sv @@
// ----------------------------------------------------------------------------
// pat_queue
// short result queue between the classifier and the result port
// ----------------------------------------------------------------------------
`default_nettype none

module pat_queue #(
  parameter int unsigned DEPTH = pat_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pat_pkg::res_push_t wr,
  input  wire logic               rd,
  output pat_pkg::out_item_t      rd_data,
  output logic                    empty,
  output logic                    full
);
  import pat_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  out_item_t     mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FULL_CNT);
  assign do_wr   = wr.valid && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr.data;
    end
  end

endmodule

`default_nettype wire

@@ sv/pat_section_parser_unit.sv @@
// ----------------------------------------------------------------------------
// pat_section_parser_unit
// program association table section parser, byte in, entries and status out
// ----------------------------------------------------------------------------
// Takes one section byte per clock and keeps that rate as long as the result
// queue has room; every byte is classified in the cycle it is accepted and any
// result it causes is written into a QUEUE_DEPTH-entry queue, where it can be
// popped from the next cycle on. in_full follows only the queue fill, so the
// input stalls only when QUEUE_DEPTH results are waiting. The expected table
// id register is written through the cfg channel, which is always ready.
`default_nettype none

module pat_section_parser_unit #(
  parameter int unsigned MAX_SECTION_BYTES = pat_pkg::MAX_SECTION_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH       = pat_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire pat_pkg::in_item_t  in_data,
  output logic                    in_full,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output pat_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);
  import pat_pkg::*;

  logic [7:0] exp_tid_r;
  logic       in_acc;
  res_push_t  res;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_tid_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      exp_tid_r <= cfg_data;
    end
  end

  pat_front #(
    .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .item     (in_data),
    .exp_tid  (exp_tid_r),
    .res      (res)
  );

  pat_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (res),
    .rd      (out_pop),
    .rd_data (out_data),
    .empty   (out_empty),
    .full    (in_full)
  );

  a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_full && out_empty))
    else $error("queue reports full and empty together");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("result pending right after reset");

  a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.result_kind == KIND_ENTRY) |->
      (out_data.program_number != 16'h0000 && out_data.stream_id == 16'h0000))
    else $error("entry item with program number zero or header fields");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.result_kind == KIND_REJECT) |->
      (out_data.program_number == 16'h0000 && out_data.stream_id == 16'h0000))
    else $error("reject item carries payload");

endmodule

`default_nettype wire
